// ===== sv/assert_macros.svh =====
// Assertion macros shared by the report filter RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ARFD_ASSERT(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("assertion failed");
`define ARFD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`else
`define ARFD_ASSERT(label, clk, rst_n, expr)
`define ARFD_ASSERT_IMPL(label, clk, rst_n, ante, cons)
`endif
`endif

// ===== sv/arfd_pkg.sv =====
// Shared constants and types of the advertising report filter
`default_nettype none
package arfd_pkg;
  localparam int TABLE_ENTRIES_DEF = 8;
  localparam int NAME_BYTES_DEF = 30;
  localparam logic [7:0] TYPE_SERVICE_DATA = 8'h16;
  localparam logic [7:0] TYPE_COMPLETE_NAME = 8'h09;
  localparam logic [15:0] UUID_RESET = 16'hFEA6;
  localparam logic [7:0] LAST_POSITION = 8'd255;

  localparam logic [1:0] OP_BYTE = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [2:0] ST_NO_MATCH = 3'd0;
  localparam logic [2:0] ST_ADDED = 3'd1;
  localparam logic [2:0] ST_PRESENT = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_READ = 3'd4;
  localparam logic [2:0] ST_EMPTY = 3'd5;

  typedef struct packed {
    logic valid;
    logic found;
  } chain_ctl_t;
endpackage
`default_nettype wire

// ===== sv/arfd_cell.sv =====
// One table entry cell: holds a stored name and address, compares the passing query
`default_nettype none
module arfd_cell #(
  parameter int NAME_BYTES = arfd_pkg::NAME_BYTES_DEF,
  parameter int IW = 3,
  parameter int CW = 4,
  parameter int IDX = 0
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire [CW-1:0]              cnt,
  input  wire                       wr_en,
  input  wire [NAME_BYTES*8-1:0]    wr_name,
  input  wire [47:0]                wr_addr,
  input  wire [4:0]                 rd_pos,
  output logic [7:0]                rd_byte,
  output logic [47:0]               rd_addr,
  input  arfd_pkg::chain_ctl_t      ctl_in,
  input  wire [NAME_BYTES*8-1:0]    name_in,
  input  wire [IW-1:0]              idx_in,
  input  wire [47:0]                addr_in,
  output arfd_pkg::chain_ctl_t      ctl_out,
  output logic [NAME_BYTES*8-1:0]   name_out,
  output logic [IW-1:0]             idx_out,
  output logic [47:0]               addr_out
);
  logic [NAME_BYTES*8-1:0] name_r;
  logic [47:0] addr_r;
  arfd_pkg::chain_ctl_t ctl_r;
  logic [NAME_BYTES*8-1:0] qname_r;
  logic [IW-1:0] idx_r;
  logic [47:0] qaddr_r;
  logic occupied;
  logic hit;

  assign occupied = CW'(IDX) < cnt;
  assign hit = ctl_in.valid && !ctl_in.found && occupied && (name_r == name_in);

  always_comb begin
    rd_byte = 8'd0;
    for (int b = 0; b < NAME_BYTES; b++) begin
      if (rd_pos == 5'(b)) begin
        rd_byte = name_r[b*8 +: 8];
      end
    end
  end
  assign rd_addr = addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else begin
      ctl_r.valid <= ctl_in.valid;
      ctl_r.found <= ctl_in.found | hit;
    end
    if (wr_en) begin
      name_r <= wr_name;
      addr_r <= wr_addr;
    end
    qname_r <= name_in;
    idx_r <= hit ? IW'(IDX) : idx_in;
    qaddr_r <= hit ? addr_r : addr_in;
  end

  assign ctl_out = ctl_r;
  assign name_out = qname_r;
  assign idx_out = idx_r;
  assign addr_out = qaddr_r;
endmodule
`default_nettype wire

// ===== sv/arfd_parser.sv =====
// Length/type structure walker: service UUID match and complete-name capture
`default_nettype none
module arfd_parser #(
  parameter int NAME_BYTES = arfd_pkg::NAME_BYTES_DEF
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      byte_en,
  input  wire [7:0]                adv_byte,
  input  wire                      last_byte,
  input  wire [15:0]               uuid,
  output logic                     fin_match,
  output logic [NAME_BYTES*8-1:0]  fin_name
);
  logic [7:0] pos_r, pos_nxt;
  logic [8:0] nfs_r, nfs_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] typ_r, typ_nxt;
  logic [7:0] ulo_r, ulo_nxt;
  logic stop_r, stop_nxt;
  logic match_r, match_nxt;
  logic [NAME_BYTES*8-1:0] name_r, name_nxt;
  logic [4:0] nlen_r, nlen_nxt;
  logic [8:0] start;
  logic [8:0] off;
  logic [8:0] off2;
  logic [7:0] cap;

  always_comb begin
    pos_nxt = pos_r;
    nfs_nxt = nfs_r;
    len_nxt = len_r;
    typ_nxt = typ_r;
    ulo_nxt = ulo_r;
    stop_nxt = stop_r;
    match_nxt = match_r;
    name_nxt = name_r;
    nlen_nxt = nlen_r;
    start = nfs_r - {1'b0, len_r} - 9'd1;
    off = {1'b0, pos_r} - start;
    off2 = off - 9'd2;
    cap = len_r - 8'd1;
    if (cap > 8'(NAME_BYTES)) begin
      cap = 8'(NAME_BYTES);
    end
    if (byte_en && pos_r != arfd_pkg::LAST_POSITION) begin
      pos_nxt = pos_r + 8'd1;
      if (!stop_r) begin
        if ({1'b0, pos_r} == nfs_r) begin
          if (adv_byte == 8'd0) begin
            stop_nxt = 1'b1;
          end else begin
            len_nxt = adv_byte;
            nfs_nxt = {1'b0, pos_r} + {1'b0, adv_byte} + 9'd1;
          end
        end else if (off == 9'd1) begin
          typ_nxt = adv_byte;
          if (adv_byte == arfd_pkg::TYPE_COMPLETE_NAME) begin
            name_nxt = '0;
            nlen_nxt = 5'(cap);
          end
        end else if (typ_r == arfd_pkg::TYPE_SERVICE_DATA) begin
          if (len_r >= 8'd3) begin
            if (off2 == 9'd0) begin
              ulo_nxt = adv_byte;
            end else if (off2 == 9'd1 && {adv_byte, ulo_r} == uuid) begin
              match_nxt = 1'b1;
            end
          end
        end else if (typ_r == arfd_pkg::TYPE_COMPLETE_NAME) begin
          for (int k = 0; k < NAME_BYTES; k++) begin
            if (off2 == 9'(k) && 5'(k) < nlen_r) begin
              name_nxt[k*8 +: 8] = adv_byte;
            end
          end
        end
      end
    end
  end

  always_comb begin
    logic zero_seen;
    zero_seen = 1'b0;
    fin_name = '0;
    for (int k = 0; k < NAME_BYTES; k++) begin
      if (name_nxt[k*8 +: 8] == 8'd0) begin
        zero_seen = 1'b1;
      end
      fin_name[k*8 +: 8] = zero_seen ? 8'd0 : name_nxt[k*8 +: 8];
    end
    fin_match = match_nxt && (name_nxt[7:0] != 8'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (byte_en && last_byte)) begin
      pos_r <= '0;
      nfs_r <= '0;
      len_r <= '0;
      typ_r <= '0;
      ulo_r <= '0;
      stop_r <= 1'b0;
      match_r <= 1'b0;
      name_r <= '0;
      nlen_r <= '0;
    end else begin
      pos_r <= pos_nxt;
      nfs_r <= nfs_nxt;
      len_r <= len_nxt;
      typ_r <= typ_nxt;
      ulo_r <= ulo_nxt;
      stop_r <= stop_nxt;
      match_r <= match_nxt;
      name_r <= name_nxt;
      nlen_r <= nlen_nxt;
    end
  end
endmodule
`default_nettype wire

// ===== sv/adv_report_filter_dedup_top.sv =====
// Top level of the advertising report filter with de-duplicating device table
//
//   channel   direction  handshake                 beat
//   in_*      input      in_valid / in_ready       op, byte, last, address, slot, char
//   out_*     output     out_valid / out_ready     status, index, byte, address, count
//   cfg_*     input      cfg_wr_en                 service UUID
//
// A byte, clear or read beat is taken without a search. The final byte of a report
// that matches with a name launches a query that passes down the chain of entry cells
// one cell per cycle. Synchronous active-low reset clears the parser, the entry count
// and the handshake state; stored entries need none. Input is held off while the search
// runs or a result waits untaken.
`default_nettype none
`include "assert_macros.svh"
module adv_report_filter_dedup_top #(
  parameter int TABLE_ENTRIES = arfd_pkg::TABLE_ENTRIES_DEF,
  parameter int NAME_BYTES = arfd_pkg::NAME_BYTES_DEF
) (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [1:0]  in_op,
  input  wire  [7:0]  in_adv_byte,
  input  wire         in_last_byte,
  input  wire  [47:0] in_device_address,
  input  wire  [2:0]  in_slot,
  input  wire  [4:0]  in_char_pos,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [2:0]  out_status,
  output logic [2:0]  out_entry_index,
  output logic [7:0]  out_name_byte,
  output logic [47:0] out_entry_address,
  output logic [3:0]  out_entry_count,
  input  wire         cfg_wr_en,
  input  wire  [15:0] cfg_service_uuid
);
  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = $clog2(TABLE_ENTRIES + 1);
  localparam int NW = NAME_BYTES * 8;

  typedef enum logic {S_IDLE, S_SEARCH} state_t;

  state_t state_r, state_nxt;
  logic [15:0] uuid_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic launch_r, launch_nxt;
  logic [NW-1:0] q_name_r, q_name_nxt;
  logic [47:0] q_addr_r, q_addr_nxt;
  logic out_valid_r, out_valid_nxt;
  logic [2:0] status_r, status_nxt;
  logic [2:0] index_r, index_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [47:0] addr_r, addr_nxt;

  logic acc;
  logic byte_en;
  logic fin_match;
  logic [NW-1:0] fin_name;
  logic wr_go;
  logic rd_hit;
  logic [7:0] rd_byte_sel;
  logic [47:0] rd_addr_sel;

  arfd_pkg::chain_ctl_t chain_ctl [0:TABLE_ENTRIES];
  logic [NW-1:0] chain_name [0:TABLE_ENTRIES];
  logic [IW-1:0] chain_idx [0:TABLE_ENTRIES];
  logic [47:0] chain_addr [0:TABLE_ENTRIES];
  logic [7:0] cell_byte [0:TABLE_ENTRIES-1];
  logic [47:0] cell_addr [0:TABLE_ENTRIES-1];

  assign in_ready = (state_r == S_IDLE) && (!out_valid_r || out_ready);
  assign acc = in_valid && in_ready;
  assign byte_en = acc && (in_op == arfd_pkg::OP_BYTE);

  arfd_parser #(.NAME_BYTES(NAME_BYTES)) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_en),
    .adv_byte  (in_adv_byte),
    .last_byte (in_last_byte),
    .uuid      (uuid_r),
    .fin_match (fin_match),
    .fin_name  (fin_name)
  );

  assign chain_ctl[0] = '{valid: launch_r, found: 1'b0};
  assign chain_name[0] = q_name_r;
  assign chain_idx[0] = '0;
  assign chain_addr[0] = '0;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    arfd_cell #(.NAME_BYTES(NAME_BYTES), .IW(IW), .CW(CW), .IDX(i)) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .cnt      (cnt_r),
      .wr_en    (wr_go && cnt_r == CW'(i)),
      .wr_name  (q_name_r),
      .wr_addr  (q_addr_r),
      .rd_pos   (in_char_pos),
      .rd_byte  (cell_byte[i]),
      .rd_addr  (cell_addr[i]),
      .ctl_in   (chain_ctl[i]),
      .name_in  (chain_name[i]),
      .idx_in   (chain_idx[i]),
      .addr_in  (chain_addr[i]),
      .ctl_out  (chain_ctl[i+1]),
      .name_out (chain_name[i+1]),
      .idx_out  (chain_idx[i+1]),
      .addr_out (chain_addr[i+1])
    );
  end

  always_comb begin
    rd_hit = 1'b0;
    rd_byte_sel = 8'd0;
    rd_addr_sel = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (i < 8 && in_slot == 3'(i) && CW'(i) < cnt_r) begin
        rd_hit = 1'b1;
        rd_byte_sel = cell_byte[i];
        rd_addr_sel = cell_addr[i];
      end
    end
  end

  assign wr_go = (state_r == S_SEARCH) && chain_ctl[TABLE_ENTRIES].valid
                 && !chain_ctl[TABLE_ENTRIES].found && cnt_r < CW'(TABLE_ENTRIES);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r;
    launch_nxt = 1'b0;
    q_name_nxt = q_name_r;
    q_addr_nxt = q_addr_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt = status_r;
    index_nxt = index_r;
    byte_nxt = byte_r;
    addr_nxt = addr_r;
    if (acc) begin
      case (in_op)
        arfd_pkg::OP_BYTE: begin
          if (in_last_byte) begin
            if (fin_match) begin
              state_nxt = S_SEARCH;
              launch_nxt = 1'b1;
              q_name_nxt = fin_name;
              q_addr_nxt = in_device_address;
            end else begin
              out_valid_nxt = 1'b1;
              status_nxt = arfd_pkg::ST_NO_MATCH;
              index_nxt = 3'd0;
              byte_nxt = 8'd0;
              addr_nxt = '0;
            end
          end
        end
        arfd_pkg::OP_CLEAR: begin
          cnt_nxt = '0;
          out_valid_nxt = 1'b1;
          status_nxt = arfd_pkg::ST_EMPTY;
          index_nxt = 3'd0;
          byte_nxt = 8'd0;
          addr_nxt = '0;
        end
        arfd_pkg::OP_READ: begin
          out_valid_nxt = 1'b1;
          index_nxt = in_slot;
          if (rd_hit) begin
            status_nxt = arfd_pkg::ST_READ;
            byte_nxt = (in_char_pos < 5'(NAME_BYTES)) ? rd_byte_sel : 8'd0;
            addr_nxt = rd_addr_sel;
          end else begin
            status_nxt = arfd_pkg::ST_EMPTY;
            byte_nxt = 8'd0;
            addr_nxt = '0;
          end
        end
        default: begin
        end
      endcase
    end
    if (state_r == S_SEARCH && chain_ctl[TABLE_ENTRIES].valid) begin
      state_nxt = S_IDLE;
      out_valid_nxt = 1'b1;
      byte_nxt = 8'd0;
      if (chain_ctl[TABLE_ENTRIES].found) begin
        status_nxt = arfd_pkg::ST_PRESENT;
        index_nxt = 3'(chain_idx[TABLE_ENTRIES]);
        addr_nxt = chain_addr[TABLE_ENTRIES];
      end else if (!wr_go) begin
        status_nxt = arfd_pkg::ST_FULL;
        index_nxt = 3'd0;
        addr_nxt = '0;
      end else begin
        status_nxt = arfd_pkg::ST_ADDED;
        index_nxt = 3'(cnt_r);
        addr_nxt = q_addr_r;
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      uuid_r <= arfd_pkg::UUID_RESET;
      cnt_r <= '0;
      launch_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        uuid_r <= cfg_service_uuid;
      end
      cnt_r <= cnt_nxt;
      launch_r <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    q_name_r <= q_name_nxt;
    q_addr_r <= q_addr_nxt;
    status_r <= status_nxt;
    index_r <= index_nxt;
    byte_r <= byte_nxt;
    addr_r <= addr_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_entry_index = index_r;
  assign out_name_byte = byte_r;
  assign out_entry_address = addr_r;
  assign out_entry_count = 4'(cnt_r);

  `ARFD_ASSERT(a_cnt_bound, clk, rst_n, cnt_r <= CW'(TABLE_ENTRIES))
  `ARFD_ASSERT_IMPL(a_tail_in_search, clk, rst_n, chain_ctl[TABLE_ENTRIES].valid, state_r == S_SEARCH)
  `ARFD_ASSERT_IMPL(a_found_below_cnt, clk, rst_n, chain_ctl[TABLE_ENTRIES].valid && chain_ctl[TABLE_ENTRIES].found, CW'(chain_idx[TABLE_ENTRIES]) < cnt_r)
  `ARFD_ASSERT_IMPL(a_launch_blocks, clk, rst_n, launch_r, !in_ready && !out_valid_r)
endmodule
`default_nettype wire
